// ===== rtl/core/ubxfr_pkg.sv =====
package ubxfr_pkg;

	localparam logic [7:0] SYNC_FIRST = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam logic [15:0] TIMEOUT_RESET = 16'd10;
	localparam logic [9:0] MAX_LENGTH_RESET = 10'd500;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = 2;
	localparam int unsigned QCW = 3;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic {
		CFG_TIMEOUT = 1'b0,
		CFG_MAX_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [8:0] {
		PH_SYNC1 = 9'b000000001,
		PH_SYNC2 = 9'b000000010,
		PH_CLASS = 9'b000000100,
		PH_ID = 9'b000001000,
		PH_LEN_LO = 9'b000010000,
		PH_LEN_HI = 9'b000100000,
		PH_DATA = 9'b001000000,
		PH_CK_A = 9'b010000000,
		PH_CK_B = 9'b100000000
	} phase_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] msg_class;
		logic [7:0] msg_id;
		logic [9:0] payload_length;
		logic [7:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic full;
	} queue_status_t;

endpackage

// ===== rtl/core/ubx_frame_receiver_core.sv =====
// Channel   Handshake                  Payload
// request   req_valid / req_stall      cmd, data_byte, read_index
// response  rsp_valid / rsp_stall      kind, msg_class, msg_id, payload_length, read_data
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One request is taken every cycle unless req_stall is high; a result is registered in the s1 stage, then queued.
// The payload store is a single-port-write, single-port-read memory with registered read data.
// Reset clears all control state; the payload store is not cleared and needs no sweep.
// A stalled response is held in a four-item queue; requests keep flowing until a pending result would fill it.
module ubx_frame_receiver_core
	import ubxfr_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 512
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] cmd,
	input logic [7:0] data_byte,
	input logic [8:0] read_index,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic kind,
	output logic [7:0] msg_class,
	output logic [7:0] msg_id,
	output logic [9:0] payload_length,
	output logic [7:0] read_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data
);

	localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [16:0] DEPTH_LIM = 17'(BUFFER_DEPTH);

	logic [15:0] timeout_q;
	logic [9:0] max_len_q;

	phase_t phase_q, phase_d;
	logic [7:0] class_q, class_d;
	logic [7:0] id_q, id_d;
	logic [9:0] len_q, len_d;
	logic [9:0] wpos_q, wpos_d;
	logic [7:0] sum_a_q, sum_a_d;
	logic [7:0] sum_b_q, sum_b_d;
	logic [15:0] idle_q, idle_d;
	logic timer_armed_q, timer_armed_d;

	logic req_acc;
	logic frame_ok;
	logic mem_we;
	logic rd_en;
	logic rd_in_range;

	logic [7:0] store [BUFFER_DEPTH];
	logic [7:0] mem_rd_s1;

	logic res_valid_s1;
	logic rd_zero_s1;
	rsp_t res_s1;
	rsp_t push_item;
	rsp_t head_item;
	queue_status_t qstat;

	assign req_acc = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rd_in_range = ({8'b0, read_index} < DEPTH_LIM);
	assign rd_en = req_acc && (cmd == CMD_READ) && rd_in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			max_len_q <= MAX_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_MAX_LENGTH: max_len_q <= cfg_data[9:0];
			endcase
		end
	end

	always_comb begin
		logic [7:0] sum_a_add;
		logic [7:0] sum_b_add;
		logic [16:0] len_full;
		logic [9:0] wpos_inc;
		logic [16:0] tick_cnt;

		sum_a_add = sum_a_q + data_byte;
		sum_b_add = sum_b_q + sum_a_add;
		len_full = {1'b0, data_byte, len_q[7:0]};
		wpos_inc = wpos_q + 10'd1;
		tick_cnt = {1'b0, idle_q} + 17'd1;

		phase_d = phase_q;
		class_d = class_q;
		id_d = id_q;
		len_d = len_q;
		wpos_d = wpos_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		idle_d = idle_q;
		timer_armed_d = timer_armed_q;
		frame_ok = 1'b0;
		mem_we = 1'b0;

		if (req_acc) begin
			unique case (cmd_t'(cmd))
				CMD_BYTE: begin
					idle_d = '0;
					timer_armed_d = 1'b1;
					unique case (phase_q)
						PH_SYNC1: begin
							if (data_byte == SYNC_FIRST) begin
								phase_d = PH_SYNC2;
							end
						end
						PH_SYNC2: begin
							if (data_byte == SYNC_SECOND) begin
								sum_a_d = '0;
								sum_b_d = '0;
								phase_d = PH_CLASS;
							end else begin
								phase_d = PH_SYNC1;
							end
						end
						PH_CLASS: begin
							class_d = data_byte;
							sum_a_d = sum_a_add;
							sum_b_d = sum_b_add;
							phase_d = PH_ID;
						end
						PH_ID: begin
							id_d = data_byte;
							sum_a_d = sum_a_add;
							sum_b_d = sum_b_add;
							phase_d = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							len_d = {2'b0, data_byte};
							sum_a_d = sum_a_add;
							sum_b_d = sum_b_add;
							phase_d = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							len_d = len_full[9:0];
							sum_a_d = sum_a_add;
							sum_b_d = sum_b_add;
							wpos_d = '0;
							if (len_full > {7'b0, max_len_q} || len_full > DEPTH_LIM) begin
								phase_d = PH_SYNC1;
							end else if (len_full == '0) begin
								phase_d = PH_CK_A;
							end else begin
								phase_d = PH_DATA;
							end
						end
						PH_DATA: begin
							mem_we = 1'b1;
							wpos_d = wpos_inc;
							sum_a_d = sum_a_add;
							sum_b_d = sum_b_add;
							if (wpos_inc >= len_q) begin
								phase_d = PH_CK_A;
							end
						end
						PH_CK_A: begin
							if (data_byte == sum_a_q) begin
								phase_d = PH_CK_B;
							end else begin
								phase_d = PH_SYNC1;
							end
						end
						PH_CK_B: begin
							phase_d = PH_SYNC1;
							if (data_byte == sum_b_q) begin
								frame_ok = 1'b1;
								timer_armed_d = 1'b0;
							end
						end
						default: phase_d = PH_SYNC1;
					endcase
				end
				CMD_TICK: begin
					if (timer_armed_q) begin
						if (tick_cnt >= {1'b0, timeout_q}) begin
							phase_d = PH_SYNC1;
							timer_armed_d = 1'b0;
							idle_d = '0;
						end else begin
							idle_d = tick_cnt[15:0];
						end
					end
				end
				CMD_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			class_q <= '0;
			id_q <= '0;
			len_q <= '0;
			wpos_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			idle_q <= '0;
			timer_armed_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			class_q <= class_d;
			id_q <= id_d;
			len_q <= len_d;
			wpos_q <= wpos_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			idle_q <= idle_d;
			timer_armed_q <= timer_armed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[AW'(wpos_q)] <= data_byte;
		end
		if (rd_en) begin
			mem_rd_s1 <= store[AW'(read_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= frame_ok || (req_acc && (cmd == CMD_READ));
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ok) begin
			res_s1.kind <= KIND_FRAME;
			res_s1.msg_class <= class_q;
			res_s1.msg_id <= id_q;
			res_s1.payload_length <= len_q;
			res_s1.read_data <= '0;
			rd_zero_s1 <= 1'b1;
		end else if (req_acc && (cmd == CMD_READ)) begin
			res_s1.kind <= KIND_READ;
			res_s1.msg_class <= '0;
			res_s1.msg_id <= '0;
			res_s1.payload_length <= '0;
			res_s1.read_data <= '0;
			rd_zero_s1 <= !rd_in_range;
		end
	end

	always_comb begin
		push_item = res_s1;
		push_item.read_data = rd_zero_s1 ? 8'd0 : mem_rd_s1;
	end

	ubxfr_rsp_queue u_rsp_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_valid_s1),
		.wr_item(push_item),
		.head_valid(rsp_valid),
		.head_stall(rsp_stall),
		.head_item(head_item),
		.status(qstat)
	);

	assign req_stall = ({1'b0, qstat.count} + 4'(res_valid_s1)) >= 4'(QDEPTH);

	assign kind = head_item.kind;
	assign msg_class = head_item.msg_class;
	assign msg_id = head_item.msg_id;
	assign payload_length = head_item.payload_length;
	assign read_data = head_item.read_data;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 |-> !qstat.full)
		else $error("result pushed into a full response queue");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (cmd == CMD_READ)) |=> (res_valid_s1 && res_s1.kind == KIND_READ))
		else $error("read item did not produce a read result");

	a_byte_arms_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (cmd == CMD_BYTE) && !frame_ok) |=> timer_armed_q)
		else $error("received byte left the idle timer disarmed");

endmodule

// ===== rtl/core/ubxfr_rsp_queue.sv =====
module ubxfr_rsp_queue
	import ubxfr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input rsp_t wr_item,
	output logic head_valid,
	input logic head_stall,
	output rsp_t head_item,
	output queue_status_t status
);

	rsp_t entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic pop;

	assign head_valid = (count_q != '0);
	assign pop = head_valid && !head_stall;
	assign head_item = entry_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.full = (count_q == QCW'(QDEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (wr_en && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !wr_en) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule
